### design/awm_pkg.sv
// ----------------------------------------------------------------------------
// Animation weight mixer package
// Shared types, codes and constants of the animation weight mixer.
// ----------------------------------------------------------------------------
package awm_pkg;

   // Default slot counts.
   localparam int NUM_CYCLES_DEF  = 8;
   localparam int NUM_ACTIONS_DEF = 8;

   // Width of the slot walk counter; covers up to 32 slots.
   localparam int IDX_W = 5;

   // Steps of the shared divider, one quotient bit per step.
   localparam int DIV_STEPS = 64;

   // One in Q1.15.
   localparam logic [15:0] ONE_Q15 = 16'd32768;

   // Input operation codes.
   localparam logic [2:0] OP_TICK         = 3'd0;
   localparam logic [2:0] OP_START_CYCLE  = 3'd1;
   localparam logic [2:0] OP_REWEIGHT     = 3'd2;
   localparam logic [2:0] OP_CLEAR_CYCLE  = 3'd3;
   localparam logic [2:0] OP_CLEAR_ALL    = 3'd4;
   localparam logic [2:0] OP_START_ACTION = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_CYCLE   = 2'd0;
   localparam logic [1:0] KIND_ACTION  = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  slot;
      logic [15:0] target_weight;
      logic [31:0] delay;
      logic [31:0] delay_out;
      logic [31:0] clip_duration;
      logic [31:0] time_step;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  entry_slot;
      logic [15:0] entry_weight;
      logic [31:0] local_time;
      logic [31:0] sync_time;
      logic [31:0] sync_duration;
      logic        last;
   } rsp_type;

   // Action envelope phases.
   typedef enum logic [1:0] {
      PH_IN,
      PH_HOLD,
      PH_OUT
   } act_phase_type;

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SETUP,
      ST_TIME,
      ST_TIME_WAIT,
      ST_ACT_ADD,
      ST_ACT_EVAL,
      ST_ACT_WAIT,
      ST_ACT_NEXT,
      ST_CYC_EVAL,
      ST_CYC_WAIT,
      ST_CYC_ACC,
      ST_CYC_NEXT,
      ST_DUR,
      ST_DUR_WAIT,
      ST_REP_CYC,
      ST_REP_CYC_WAIT,
      ST_REP_CYC_NEXT,
      ST_REP_ACT,
      ST_SUMMARY
   } state_type;

   // Datapath commands.
   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_SETUP,
      CMD_TIME_START,
      CMD_TIME_END,
      CMD_ACT_ADD,
      CMD_ACT_EVAL,
      CMD_ACT_END,
      CMD_ACC_CLEAR,
      CMD_CYC_EVAL,
      CMD_CYC_END,
      CMD_CYC_ACC,
      CMD_DUR_START,
      CMD_DUR_END,
      CMD_REP_CYC_START,
      CMD_REP_CYC_END,
      CMD_REP_ACT,
      CMD_SUMMARY
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic cyc_live;
      logic act_live;
      logic div_busy;
   } status_type;

endpackage

### design/awm_div.sv
// ----------------------------------------------------------------------------
// Shared divider
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module awm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        busy,
   output logic [63:0] quot,
   output logic [31:0] rem
);
   import awm_pkg::*;

   localparam int CW = $clog2(DIV_STEPS);

   logic [63:0]   quo_ff;
   logic [31:0]   rem_ff;
   logic [31:0]   den_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [32:0]   trial;
   logic          fits;
   logic [31:0]   rem_in;

   // One restoring step.
   always_comb begin
      trial  = {rem_ff, quo_ff[63]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         quo_ff  <= num;
         rem_ff  <= '0;
         den_ff  <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[62:0], fits};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

### design/awm_ctrl.sv
// ----------------------------------------------------------------------------
// Mixer controller
// Sequences set-up items and the slot walks of a tick over the datapath.
// ----------------------------------------------------------------------------
module awm_ctrl #(
   parameter int NUM_CYCLES  = awm_pkg::NUM_CYCLES_DEF,
   parameter int NUM_ACTIONS = awm_pkg::NUM_ACTIONS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2:0]          req_op,
   input  awm_pkg::status_type status,
   output awm_pkg::cmd_type    cmd,
   output logic                busy
);
   import awm_pkg::*;

   localparam logic [IDX_W-1:0] LAST_CYC = IDX_W'(NUM_CYCLES - 1);
   localparam logic [IDX_W-1:0] LAST_ACT = IDX_W'(NUM_ACTIONS - 1);

   state_type        state_ff, next_state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= next_state_in;
         idx_ff   <= idx_in;
      end
   end

   // Next state and slot counter.
   always_comb begin
      next_state_in = state_ff;
      idx_in        = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               next_state_in = (req_op == OP_TICK) ? ST_TIME : ST_SETUP;
            end
         end
         ST_SETUP: next_state_in = ST_IDLE;
         ST_TIME:  next_state_in = ST_TIME_WAIT;
         ST_TIME_WAIT: begin
            if (!status.div_busy) begin
               idx_in        = '0;
               next_state_in = ST_ACT_ADD;
            end
         end
         ST_ACT_ADD:  next_state_in = status.act_live ? ST_ACT_EVAL : ST_ACT_NEXT;
         ST_ACT_EVAL: next_state_in = ST_ACT_WAIT;
         ST_ACT_WAIT: begin
            if (!status.div_busy) begin
               next_state_in = ST_ACT_NEXT;
            end
         end
         ST_ACT_NEXT: begin
            if (idx_ff == LAST_ACT) begin
               idx_in        = '0;
               next_state_in = ST_CYC_EVAL;
            end else begin
               idx_in        = idx_ff + 1'b1;
               next_state_in = ST_ACT_ADD;
            end
         end
         ST_CYC_EVAL: next_state_in = status.cyc_live ? ST_CYC_WAIT : ST_CYC_NEXT;
         ST_CYC_WAIT: begin
            if (!status.div_busy) begin
               next_state_in = ST_CYC_ACC;
            end
         end
         ST_CYC_ACC: next_state_in = ST_CYC_NEXT;
         ST_CYC_NEXT: begin
            if (idx_ff == LAST_CYC) begin
               idx_in        = '0;
               next_state_in = ST_DUR;
            end else begin
               idx_in        = idx_ff + 1'b1;
               next_state_in = ST_CYC_EVAL;
            end
         end
         ST_DUR: next_state_in = ST_DUR_WAIT;
         ST_DUR_WAIT: begin
            if (!status.div_busy) begin
               next_state_in = ST_REP_CYC;
            end
         end
         ST_REP_CYC: next_state_in = status.cyc_live ? ST_REP_CYC_WAIT : ST_REP_CYC_NEXT;
         ST_REP_CYC_WAIT: begin
            if (!status.div_busy) begin
               next_state_in = ST_REP_CYC_NEXT;
            end
         end
         ST_REP_CYC_NEXT: begin
            if (idx_ff == LAST_CYC) begin
               idx_in        = '0;
               next_state_in = ST_REP_ACT;
            end else begin
               idx_in        = idx_ff + 1'b1;
               next_state_in = ST_REP_CYC;
            end
         end
         ST_REP_ACT: begin
            if (idx_ff == LAST_ACT) begin
               idx_in        = '0;
               next_state_in = ST_SUMMARY;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SUMMARY: next_state_in = ST_IDLE;
         default:    next_state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.op  = CMD_NOP;
      cmd.idx = idx_ff;
      case (state_ff)
         ST_IDLE:      cmd.op = start ? CMD_LOAD : CMD_NOP;
         ST_SETUP:     cmd.op = CMD_SETUP;
         ST_TIME:      cmd.op = CMD_TIME_START;
         ST_TIME_WAIT: cmd.op = status.div_busy ? CMD_NOP : CMD_TIME_END;
         ST_ACT_ADD:   cmd.op = status.act_live ? CMD_ACT_ADD : CMD_NOP;
         ST_ACT_EVAL:  cmd.op = CMD_ACT_EVAL;
         ST_ACT_WAIT:  cmd.op = status.div_busy ? CMD_NOP : CMD_ACT_END;
         ST_ACT_NEXT:  cmd.op = (idx_ff == LAST_ACT) ? CMD_ACC_CLEAR : CMD_NOP;
         ST_CYC_EVAL:  cmd.op = status.cyc_live ? CMD_CYC_EVAL : CMD_NOP;
         ST_CYC_WAIT:  cmd.op = status.div_busy ? CMD_NOP : CMD_CYC_END;
         ST_CYC_ACC:   cmd.op = CMD_CYC_ACC;
         ST_DUR:       cmd.op = CMD_DUR_START;
         ST_DUR_WAIT:  cmd.op = status.div_busy ? CMD_NOP : CMD_DUR_END;
         ST_REP_CYC:   cmd.op = status.cyc_live ? CMD_REP_CYC_START : CMD_NOP;
         ST_REP_CYC_WAIT: cmd.op = status.div_busy ? CMD_NOP : CMD_REP_CYC_END;
         ST_REP_ACT:   cmd.op = status.act_live ? CMD_REP_ACT : CMD_NOP;
         ST_SUMMARY:   cmd.op = CMD_SUMMARY;
         default:      cmd.op = CMD_NOP;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### design/awm_datapath.sv
// ----------------------------------------------------------------------------
// Mixer datapath
// Slot state, accumulators, the shared divider and the result register.
// ----------------------------------------------------------------------------
module awm_datapath #(
   parameter int NUM_CYCLES  = awm_pkg::NUM_CYCLES_DEF,
   parameter int NUM_ACTIONS = awm_pkg::NUM_ACTIONS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  awm_pkg::req_type    req_data,
   input  awm_pkg::cmd_type    cmd,
   output awm_pkg::status_type status,
   output logic                rsp_valid,
   output awm_pkg::rsp_type    rsp_data
);
   import awm_pkg::*;

   localparam int CIW = (NUM_CYCLES > 1) ? $clog2(NUM_CYCLES) : 1;
   localparam int AIW = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
   localparam int AWW = 16 + CIW + 1;
   localparam int ADW = AWW + 32;

   // Latched item.
   req_type req_ff;

   // Cycle slots.
   logic [NUM_CYCLES-1:0] cyc_live_ff;
   logic [NUM_CYCLES-1:0] cyc_clear_ff;
   logic [15:0]           cyc_weight_ff [NUM_CYCLES];
   logic [15:0]           cyc_target_ff [NUM_CYCLES];
   logic [31:0]           cyc_delay_ff  [NUM_CYCLES];
   logic [31:0]           cyc_len_ff    [NUM_CYCLES];

   // Action slots.
   logic [NUM_ACTIONS-1:0] act_live_ff;
   act_phase_type          act_phase_ff  [NUM_ACTIONS];
   logic [31:0]            act_elap_ff   [NUM_ACTIONS];
   logic [31:0]            act_fin_ff    [NUM_ACTIONS];
   logic [31:0]            act_fout_ff   [NUM_ACTIONS];
   logic [31:0]            act_len_ff    [NUM_ACTIONS];
   logic [15:0]            act_weight_ff [NUM_ACTIONS];

   logic [31:0]    time_ff;
   logic [31:0]    dur_ff;
   logic [AWW-1:0] accw_ff;
   logic [ADW-1:0] accd_ff;
   logic           pend_ff;
   logic           act_out_ff;
   logic           cyc_up_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic [CIW-1:0] ci, cs;
   logic [AIW-1:0] ai, as_slot;
   logic [15:0]    tw_sat;
   logic [32:0]    elap_sum;
   logic [31:0]    step;
   logic [15:0]    cw, ct;
   logic           cyc_up;
   logic [15:0]    cyc_diff;
   logic [31:0]    ae, afi, afo, alen;
   logic           div_start;
   logic [63:0]    div_num;
   logic [31:0]    div_den;
   logic           div_busy;
   logic [63:0]    div_quot;
   logic [31:0]    div_rem;
   logic [15:0]    out_w;
   logic [31:0]    lt_sat;

   assign ci      = cmd.idx[CIW-1:0];
   assign ai      = cmd.idx[AIW-1:0];
   assign cs      = CIW'(req_ff.slot);
   assign as_slot = AIW'(req_ff.slot);
   assign step    = req_ff.time_step;
   assign tw_sat  = (req_ff.target_weight > ONE_Q15) ? ONE_Q15 : req_ff.target_weight;

   // Values of the addressed slots.
   always_comb begin
      cw       = cyc_weight_ff[ci];
      ct       = cyc_target_ff[ci];
      cyc_up   = ct >= cw;
      cyc_diff = cyc_up ? 16'(ct - cw) : 16'(cw - ct);
      ae       = act_elap_ff[ai];
      afi      = act_fin_ff[ai];
      afo      = act_fout_ff[ai];
      alen     = act_len_ff[ai];
      elap_sum = {1'b0, ae} + {1'b0, step};
   end

   // Divider operands for the command at hand.
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (cmd.op)
         CMD_TIME_START: begin
            if (dur_ff != '0) begin
               div_start = 1'b1;
               div_num   = 64'({1'b0, time_ff} + {1'b0, step});
               div_den   = dur_ff;
            end
         end
         CMD_ACT_EVAL: begin
            if (act_phase_ff[ai] == PH_IN && ae < afi) begin
               div_start = 1'b1;
               div_num   = 64'({ae, 15'b0});
               div_den   = afi;
            end else if (act_phase_ff[ai] == PH_OUT && ae < alen && afo != '0) begin
               div_start = 1'b1;
               div_num   = 64'({32'(alen - ae), 15'b0});
               div_den   = afo;
            end
         end
         CMD_CYC_EVAL: begin
            if (cyc_delay_ff[ci] > step) begin
               div_start = 1'b1;
               div_num   = 64'({32'b0, cyc_diff} * {16'b0, step});
               div_den   = cyc_delay_ff[ci];
            end
         end
         CMD_DUR_START: begin
            if (accw_ff != '0) begin
               div_start = 1'b1;
               div_num   = 64'(accd_ff);
               div_den   = 32'(accw_ff);
            end
         end
         CMD_REP_CYC_START: begin
            if (dur_ff != '0) begin
               div_start = 1'b1;
               div_num   = {32'b0, time_ff} * {32'b0, cyc_len_ff[ci]};
               div_den   = dur_ff;
            end
         end
         default: div_start = 1'b0;
      endcase
   end

   awm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // Fade-out weight clamps at one; cycle local time saturates.
   always_comb begin
      if (act_out_ff && (div_quot[63:16] != '0 || div_quot[15:0] > ONE_Q15)) begin
         out_w = ONE_Q15;
      end else begin
         out_w = div_quot[15:0];
      end
      lt_sat = (div_quot[63:32] != '0) ? '1 : div_quot[31:0];
   end

   // Marks that a division was started for the step at hand.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (div_start) begin
         pend_ff <= 1'b1;
      end else if (cmd.op inside {CMD_TIME_END, CMD_ACT_END, CMD_CYC_END, CMD_DUR_END,
                                  CMD_REP_CYC_END}) begin
         pend_ff <= 1'b0;
      end
   end

   // Result strobe, one cycle per reported beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.op inside {CMD_REP_CYC_END, CMD_REP_ACT, CMD_SUMMARY});
      end
   end

   // State updates per command.
   always_ff @(posedge clock) begin
      if (reset) begin
         cyc_live_ff  <= '0;
         act_live_ff  <= '0;
         time_ff      <= '0;
         dur_ff       <= '0;
      end else begin
         case (cmd.op)
            CMD_LOAD: req_ff <= req_data;
            CMD_SETUP: begin
               case (req_ff.op)
                  OP_START_CYCLE, OP_REWEIGHT, OP_CLEAR_CYCLE: begin
                     if (32'(req_ff.slot) < NUM_CYCLES &&
                         (req_ff.op == OP_START_CYCLE || cyc_live_ff[cs])) begin
                        if (req_ff.op == OP_START_CYCLE) begin
                           cyc_live_ff[cs]   <= 1'b1;
                           cyc_weight_ff[cs] <= '0;
                           cyc_clear_ff[cs]  <= 1'b0;
                           cyc_len_ff[cs]    <= req_ff.clip_duration;
                        end
                        cyc_target_ff[cs] <= (req_ff.op == OP_CLEAR_CYCLE) ? '0 : tw_sat;
                        cyc_delay_ff[cs]  <= req_ff.delay;
                        if (req_ff.op == OP_CLEAR_CYCLE) begin
                           cyc_clear_ff[cs] <= 1'b1;
                        end
                     end
                  end
                  OP_CLEAR_ALL: begin
                     for (int s = 0; s < NUM_CYCLES; s++) begin
                        if (cyc_live_ff[s]) begin
                           cyc_target_ff[s] <= '0;
                           cyc_delay_ff[s]  <= req_ff.delay;
                        end
                     end
                  end
                  OP_START_ACTION: begin
                     if (32'(req_ff.slot) < NUM_ACTIONS) begin
                        act_live_ff[as_slot]   <= 1'b1;
                        act_phase_ff[as_slot]  <= PH_IN;
                        act_elap_ff[as_slot]   <= '0;
                        act_weight_ff[as_slot] <= '0;
                        act_fin_ff[as_slot]    <= req_ff.delay;
                        act_fout_ff[as_slot]   <= req_ff.delay_out;
                        act_len_ff[as_slot]    <= req_ff.clip_duration;
                     end
                  end
                  default: ;
               endcase
            end
            CMD_TIME_START: begin
               if (dur_ff == '0) begin
                  time_ff <= '0;
               end
            end
            CMD_TIME_END: begin
               if (pend_ff) begin
                  time_ff <= div_rem;
               end
            end
            CMD_ACT_ADD: begin
               act_elap_ff[ai] <= elap_sum[32] ? '1 : elap_sum[31:0];
            end
            CMD_ACT_EVAL: begin
               act_out_ff <= (act_phase_ff[ai] == PH_OUT);
               case (act_phase_ff[ai])
                  PH_IN: begin
                     if (ae >= afi) begin
                        act_phase_ff[ai]  <= PH_HOLD;
                        act_weight_ff[ai] <= ONE_Q15;
                     end
                  end
                  PH_HOLD: begin
                     if ({1'b0, ae} + {1'b0, afo} >= {1'b0, alen}) begin
                        act_phase_ff[ai] <= PH_OUT;
                     end
                  end
                  default: begin
                     if (ae >= alen) begin
                        act_weight_ff[ai] <= '0;
                        act_live_ff[ai]   <= 1'b0;
                     end else if (afo == '0) begin
                        act_weight_ff[ai] <= '0;
                     end
                  end
               endcase
            end
            CMD_ACT_END: begin
               if (pend_ff) begin
                  act_weight_ff[ai] <= out_w;
               end
            end
            CMD_ACC_CLEAR: begin
               accw_ff <= '0;
               accd_ff <= '0;
            end
            CMD_CYC_EVAL: begin
               act_out_ff <= 1'b0;
               cyc_up_ff  <= cyc_up;
               if (cyc_delay_ff[ci] <= step) begin
                  cyc_weight_ff[ci] <= ct;
                  cyc_delay_ff[ci]  <= '0;
                  if (ct == '0 && cyc_clear_ff[ci]) begin
                     cyc_live_ff[ci] <= 1'b0;
                  end
               end else begin
                  cyc_delay_ff[ci] <= cyc_delay_ff[ci] - step;
               end
            end
            CMD_CYC_END: begin
               if (pend_ff) begin
                  cyc_weight_ff[ci] <= cyc_up_ff ? 16'(cw + div_quot[15:0])
                                                 : 16'(cw - div_quot[15:0]);
               end
            end
            CMD_CYC_ACC: begin
               if (cyc_live_ff[ci]) begin
                  accw_ff <= accw_ff + AWW'(cw);
                  accd_ff <= accd_ff + ADW'({32'b0, cw} * {16'b0, cyc_len_ff[ci]});
               end
            end
            CMD_DUR_START: begin
               if (accw_ff == '0) begin
                  dur_ff <= '0;
               end
            end
            CMD_DUR_END: begin
               if (pend_ff) begin
                  dur_ff <= div_quot[31:0];
               end
            end
            CMD_REP_CYC_END: begin
               rsp_ff.kind           <= KIND_CYCLE;
               rsp_ff.entry_slot     <= 3'(cmd.idx);
               rsp_ff.entry_weight   <= cw;
               rsp_ff.local_time     <= pend_ff ? lt_sat : '0;
               rsp_ff.sync_time      <= time_ff;
               rsp_ff.sync_duration  <= dur_ff;
               rsp_ff.last           <= 1'b0;
            end
            CMD_REP_ACT: begin
               rsp_ff.kind           <= KIND_ACTION;
               rsp_ff.entry_slot     <= 3'(cmd.idx);
               rsp_ff.entry_weight   <= act_weight_ff[ai];
               rsp_ff.local_time     <= ae;
               rsp_ff.sync_time      <= time_ff;
               rsp_ff.sync_duration  <= dur_ff;
               rsp_ff.last           <= 1'b0;
            end
            CMD_SUMMARY: begin
               rsp_ff.kind           <= KIND_SUMMARY;
               rsp_ff.entry_slot     <= '0;
               rsp_ff.entry_weight   <= '0;
               rsp_ff.local_time     <= '0;
               rsp_ff.sync_time      <= time_ff;
               rsp_ff.sync_duration  <= dur_ff;
               rsp_ff.last           <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign status.cyc_live = cyc_live_ff[ci];
   assign status.act_live = act_live_ff[ai];
   assign status.div_busy = div_busy;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

### design/animation_weight_mixer_top.sv
// A tick walks every action and cycle slot and runs its divisions one after another
// on the shared bit-serial divider: one for the sync time, one per fading action and
// per blending cycle, one for the mean duration and one per live cycle's local time.
// One item at a time; results come as one-cycle strobes that cannot be stalled.
// Synchronous reset frees all slots and zeroes the sync time and duration.
// ----------------------------------------------------------------------------
// Animation weight mixer
// Blends looping cycles and one-shot actions and reports their weights per tick.
// ----------------------------------------------------------------------------
module animation_weight_mixer_top #(
   parameter int NUM_CYCLES  = awm_pkg::NUM_CYCLES_DEF,
   parameter int NUM_ACTIONS = awm_pkg::NUM_ACTIONS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  awm_pkg::req_type req_data,
   output logic             rsp_valid,
   output awm_pkg::rsp_type rsp_data
);
   import awm_pkg::*;

   cmd_type    cmd;
   status_type status;

   awm_ctrl #(
      .NUM_CYCLES  (NUM_CYCLES),
      .NUM_ACTIONS (NUM_ACTIONS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_data.op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   awm_datapath #(
      .NUM_CYCLES  (NUM_CYCLES),
      .NUM_ACTIONS (NUM_ACTIONS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### sim/tb_animation_weight_mixer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Animation weight mixer testbench
// Drives set-up items and ticks, predicts every cycle, action and summary
// entry of each tick, and compares every field of the reported beats.
// ----------------------------------------------------------------------------
module tb_animation_weight_mixer_top;
   import awm_pkg::*;

   localparam int NCYC = 8;
   localparam int NACT = 8;
   localparam longint CYCLE_LIMIT = 3000000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    busy_q;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   animation_weight_mixer_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // Clock with a 4 ns period.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Mixer state as the testbench expects it.
   bit            cyc_live [NCYC];
   logic [15:0]   cyc_weight [NCYC];
   logic [15:0]   cyc_target [NCYC];
   logic [31:0]   cyc_delay_left [NCYC];
   bit            cyc_clearing [NCYC];
   logic [31:0]   cyc_length [NCYC];
   bit            act_live [NACT];
   act_phase_type act_phase [NACT];
   logic [31:0]   act_elapsed [NACT];
   logic [31:0]   act_fade_in [NACT];
   logic [31:0]   act_fade_out [NACT];
   logic [31:0]   act_length [NACT];
   logic [15:0]   act_weight [NACT];
   logic [31:0]   sync_time;
   logic [31:0]   sync_dur;

   req_type pending_items [$];
   rsp_type expected_beats [$];
   int      mismatches;
   int      beats_checked;
   int      ticks_sent;
   int      idle_pct;
   longint  cycle_count;

   function automatic rsp_type make_beat(logic [1:0] kind, int s, logic [15:0] w,
                                         logic [31:0] lt);
      rsp_type r;
      r.kind = kind;
      r.entry_slot = s[2:0];
      r.entry_weight = w;
      r.local_time = lt;
      r.sync_time = sync_time;
      r.sync_duration = sync_dur;
      r.last = (kind == KIND_SUMMARY);
      return r;
   endfunction

   // Advance one action envelope by a time step.
   task automatic advance_action(int s, logic [31:0] step);
      logic [32:0] sum;
      logic [63:0] w;
      sum = act_elapsed[s] + step;
      act_elapsed[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (act_phase[s] == PH_IN) begin
         if (act_elapsed[s] < act_fade_in[s]) begin
            w = (64'(act_elapsed[s]) * 32768) / act_fade_in[s];
            act_weight[s] = w[15:0];
         end else begin
            act_phase[s] = PH_HOLD;
            act_weight[s] = ONE_Q15;
         end
      end else if (act_phase[s] == PH_HOLD) begin
         if (64'(act_elapsed[s]) + act_fade_out[s] >= 64'(act_length[s]))
            act_phase[s] = PH_OUT;
      end else begin
         if (act_elapsed[s] < act_length[s]) begin
            w = 0;
            if (act_fade_out[s] != 0)
               w = (64'(act_length[s] - act_elapsed[s]) * 32768) / act_fade_out[s];
            act_weight[s] = (w > 32768) ? ONE_Q15 : w[15:0];
         end else begin
            act_weight[s] = 0;
            act_live[s] = 0;
         end
      end
   endtask

   // Move one cycle weight toward its target.
   task automatic advance_cycle(int s, logic [31:0] step);
      logic [63:0] d;
      if (cyc_delay_left[s] <= step) begin
         cyc_weight[s] = cyc_target[s];
         cyc_delay_left[s] = 0;
         if (cyc_weight[s] == 0 && cyc_clearing[s]) cyc_live[s] = 0;
      end else begin
         if (cyc_target[s] >= cyc_weight[s]) begin
            d = (64'(cyc_target[s] - cyc_weight[s]) * step) / cyc_delay_left[s];
            cyc_weight[s] = cyc_weight[s] + d[15:0];
         end else begin
            d = (64'(cyc_weight[s] - cyc_target[s]) * step) / cyc_delay_left[s];
            cyc_weight[s] = cyc_weight[s] - d[15:0];
         end
         cyc_delay_left[s] = cyc_delay_left[s] - step;
      end
   endtask

   // Apply one accepted item and queue the beats it should produce.
   task automatic predict_mix(req_type it);
      logic [15:0] tw;
      logic [63:0] accw, accd, lt;
      int s;
      tw = (it.target_weight > ONE_Q15) ? ONE_Q15 : it.target_weight;
      case (it.op)
         OP_START_CYCLE, OP_REWEIGHT, OP_CLEAR_CYCLE: begin
            s = it.slot;
            if (it.op == OP_START_CYCLE) begin
               cyc_live[s] = 1;
               cyc_weight[s] = 0;
               cyc_clearing[s] = 0;
               cyc_length[s] = it.clip_duration;
            end
            if (cyc_live[s]) begin
               cyc_target[s] = (it.op == OP_CLEAR_CYCLE) ? 16'd0 : tw;
               cyc_delay_left[s] = it.delay;
               if (it.op == OP_CLEAR_CYCLE) cyc_clearing[s] = 1;
            end
         end
         OP_CLEAR_ALL: begin
            for (int i = 0; i < NCYC; i++)
               if (cyc_live[i]) begin
                  cyc_target[i] = 0;
                  cyc_delay_left[i] = it.delay;
               end
         end
         OP_START_ACTION: begin
            s = it.slot;
            act_live[s] = 1;
            act_phase[s] = PH_IN;
            act_elapsed[s] = 0;
            act_weight[s] = 0;
            act_fade_in[s] = it.delay;
            act_fade_out[s] = it.delay_out;
            act_length[s] = it.clip_duration;
         end
         OP_TICK: begin
            if (sync_dur == 0) sync_time = 0;
            else sync_time = (64'(sync_time) + it.time_step) % sync_dur;
            for (int i = 0; i < NACT; i++)
               if (act_live[i]) advance_action(i, it.time_step);
            accw = 0;
            accd = 0;
            for (int i = 0; i < NCYC; i++)
               if (cyc_live[i]) begin
                  advance_cycle(i, it.time_step);
                  if (cyc_live[i]) begin
                     accw += cyc_weight[i];
                     accd += 64'(cyc_weight[i]) * cyc_length[i];
                  end
               end
            sync_dur = (accw != 0) ? 32'(accd / accw) : 32'd0;
            for (int i = 0; i < NCYC; i++)
               if (cyc_live[i]) begin
                  lt = 0;
                  if (sync_dur != 0) begin
                     lt = (64'(sync_time) * cyc_length[i]) / sync_dur;
                     if (lt > 64'hFFFF_FFFF) lt = 64'hFFFF_FFFF;
                  end
                  expected_beats.push_back(make_beat(KIND_CYCLE, i, cyc_weight[i],
                                                     lt[31:0]));
               end
            for (int i = 0; i < NACT; i++)
               if (act_live[i])
                  expected_beats.push_back(make_beat(KIND_ACTION, i, act_weight[i],
                                                     act_elapsed[i]));
            expected_beats.push_back(make_beat(KIND_SUMMARY, 0, 16'd0, 32'd0));
         end
         default: ;
      endcase
   endtask

   // Random time value, mostly small, sometimes anywhere in the range.
   function automatic logic [31:0] rand_time();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h0;
         2: return $urandom_range(0, 15);
         default: return $urandom_range(1, 32'h0004_0000);
      endcase
   endfunction

   function automatic req_type rand_item();
      req_type it;
      int pick;
      it.slot = $urandom_range(0, 7);
      it.target_weight = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                      : 16'($urandom_range(0, 32768));
      it.delay = rand_time();
      it.delay_out = rand_time();
      it.clip_duration = ($urandom_range(0, 7) == 0) ? $urandom()
                                                     : $urandom_range(1, 32'h0008_0000);
      it.time_step = rand_time();
      pick = $urandom_range(0, 99);
      if (pick < 45) it.op = OP_TICK;
      else if (pick < 60) it.op = OP_START_CYCLE;
      else if (pick < 70) it.op = OP_REWEIGHT;
      else if (pick < 78) it.op = OP_CLEAR_CYCLE;
      else if (pick < 81) it.op = OP_CLEAR_ALL;
      else if (pick < 96) it.op = OP_START_ACTION;
      else it.op = 3'($urandom_range(6, 7));
      return it;
   endfunction

   function automatic req_type mk(logic [2:0] op, logic [2:0] slot, logic [15:0] tw,
                                  logic [31:0] dly, logic [31:0] dout,
                                  logic [31:0] clip, logic [31:0] step);
      req_type it;
      it.op = op;
      it.slot = slot;
      it.target_weight = tw;
      it.delay = dly;
      it.delay_out = dout;
      it.clip_duration = clip;
      it.time_step = step;
      return it;
   endfunction

   // Driver: offers the next pending item at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy_q) begin
         // The offered item was just taken; offer the next one or go idle.
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_data <= pending_items.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_items.size() != 0
                   && $urandom_range(0, 99) >= idle_pct) begin
         req_data <= pending_items.pop_front();
         start <= 1'b1;
      end
   end

   // Busy as sampled at the last rising edge, for the driver.
   always @(posedge clock) busy_q <= busy;

   // Monitor: predicts accepted items and checks result beats.
   always @(posedge clock) begin
      rsp_type exp_beat;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (start && !busy) begin
            predict_mix(req_data);
            if (req_data.op == OP_TICK) ticks_sent++;
         end
         if (rsp_valid) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected beat: %p", rsp_data);
            end else begin
               exp_beat = expected_beats.pop_front();
               if (rsp_data !== exp_beat) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Beat mismatch: expected %p, got %p", exp_beat, rsp_data);
               end
            end
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_items.size() != 0 || start || expected_beats.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int phase_pct [4] = '{0, 73, 0, 29};
      start = 1'b0;
      reset = 1'b1;
      req_data = '0;
      mismatches = 0;
      beats_checked = 0;
      ticks_sent = 0;
      cycle_count = 0;
      idle_pct = 0;
      for (int i = 0; i < NCYC; i++) cyc_live[i] = 0;
      for (int i = 0; i < NACT; i++) act_live[i] = 0;
      sync_time = 0;
      sync_dur = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty tick, every op, saturated target, long clips, free-slot ops.
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
      pending_items.push_back(mk(OP_REWEIGHT, 3, 100, 5, 0, 0, 0));
      pending_items.push_back(mk(OP_CLEAR_CYCLE, 4, 0, 5, 0, 0, 0));
      pending_items.push_back(mk(OP_START_CYCLE, 0, 16'hFFFF, 32'h0002_0000, 0,
                                 32'h0001_0000, 0));
      pending_items.push_back(mk(OP_START_CYCLE, 7, 16384, 0, 0, 32'hFFFF_FFFF, 0));
      pending_items.push_back(mk(OP_START_ACTION, 7, 0, 32'h0001_0000, 32'h0001_0000,
                                 32'h0004_0000, 0));
      pending_items.push_back(mk(OP_START_ACTION, 0, 0, 0, 0, 32'h0000_8000, 0));
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_8000));
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_C000));
      pending_items.push_back(mk(OP_REWEIGHT, 0, 8000, 32'h0001_0000, 0, 0, 0));
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0001_8000));
      pending_items.push_back(mk(OP_START_CYCLE, 0, 20000, 0, 0, 32'h0003_0000, 0));
      pending_items.push_back(mk(OP_CLEAR_CYCLE, 7, 0, 32'h0001_0000, 0, 0, 0));
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_4000));
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
      pending_items.push_back(mk(OP_CLEAR_ALL, 0, 0, 32'h0000_1000, 0, 0, 0));
      pending_items.push_back(mk(3'd6, 7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_items.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_2000));
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // Random phases with and without sender idling; each ends fully drained.
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_pct[p];
         for (int n = 0; n < 100; n++) pending_items.push_back(rand_item());
         wait_drained();
      end
      repeat (2000) @(posedge clock);

      $display("Checked %0d result beats from %0d ticks over directed and random items.",
               beats_checked, ticks_sent);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d beats still expected", mismatches,
                  expected_beats.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
